// ===== hdl/bms_pkg.sv =====
// Shared types and constants of the burst memory slave.
// Used by the channel interfaces and by the top level; depends on nothing.
package bms_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned AddrW = 32;
  localparam int unsigned LenW  = 4;
  localparam int unsigned SizeW = 3;
  localparam int unsigned DataW = 32;

  localparam int unsigned MemWordsDef = 4096;
  localparam int unsigned MaxBeatsDef = 16;

  typedef enum logic [OpW-1:0] {
    OP_READ       = 2'd0,
    OP_WRITE_REQ  = 2'd1,
    OP_WRITE_DATA = 2'd2
  } opcode_e;

  localparam logic KindReadBeat = 1'b0;
  localparam logic KindWriteRsp = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic             kind;
    logic [DataW-1:0] read_data;
    logic             last;
  } rsp_t;

endpackage

// ===== hdl/bms_if.sv =====
// Valid/ready channel interfaces of the burst memory slave: request items in,
// result items out. Depends on bms_pkg for the field widths.
interface bms_in_if;
  logic                        valid;
  logic                        ready;
  logic [bms_pkg::OpW-1:0]     opcode;
  logic [bms_pkg::AddrW-1:0]   byte_address;
  logic [bms_pkg::LenW-1:0]    burst_len;
  logic [bms_pkg::SizeW-1:0]   size_log2;
  logic [bms_pkg::DataW-1:0]   write_data;

  modport source (output valid, opcode, byte_address, burst_len, size_log2, write_data,
                  input ready);
  modport sink   (input valid, opcode, byte_address, burst_len, size_log2, write_data,
                  output ready);
endinterface

interface bms_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [bms_pkg::DataW-1:0]   read_data;
  logic                        last;

  modport source (output valid, kind, read_data, last, input ready);
  modport sink   (input valid, kind, read_data, last, output ready);
endinterface

// ===== hdl/burst_memory_slave_unit.sv =====
// Burst memory slave: a flat word memory behind a burst channel; uses bms_pkg and bms_if.sv.
// Reset starts a clearing pass over all MEM_WORDS words, with no item accepted. Other
// items are accepted while the result queue has room, but a read burst holds the input
// off until its last beat is issued, sending one beat per cycle while the sink is ready.
// The first read beat passes the state register, the memory read register and the result
// queue before it is offered; a write response is queued with the final write data item.
module burst_memory_slave_unit #(
  parameter int unsigned MEM_WORDS = bms_pkg::MemWordsDef,
  parameter int unsigned MAX_BEATS = bms_pkg::MaxBeatsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bms_in_if.sink        in_i,
  bms_out_if.source     out_o
);

  localparam int unsigned MemAw = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BEATS + 1);

  // The whole word store sits in one synchronous memory with a write port and a
  // read port. Reads (read bursts), writes (write data) and the clearing pass each
  // own the memory in a different controller state, so two accesses never meet in one
  // cycle. A write followed by a read of the same word is ordered by the
  // controller: the read is issued only after the write edge.
  logic [bms_pkg::DataW-1:0] mem_q [MEM_WORDS];
  logic [bms_pkg::DataW-1:0] mem_rdata_q;
  logic                      mem_we;
  logic                      mem_re;
  logic [MemAw-1:0]          mem_waddr;
  logic [MemAw-1:0]          mem_raddr;
  logic [bms_pkg::DataW-1:0] mem_wdata;

  bms_pkg::state_e state_q, state_d;

  logic [MemAw-1:0] clr_q, clr_d;
  logic             clr_done;

  // Read burst walker.
  logic [bms_pkg::AddrW-1:0] rd_addr_q, rd_addr_d;
  logic [CntW-1:0]           rd_left_q, rd_left_d;
  logic [bms_pkg::SizeW-1:0] rd_size_q, rd_size_d;

  // A read that is in the memory this cycle; its data lands in mem_rdata_q.
  logic inf_q, inf_d;
  logic inf_last_q, inf_last_d;
  logic inf_oor_q, inf_oor_d;

  // Open write burst.
  logic                      wr_open_q, wr_open_d;
  logic [bms_pkg::AddrW-1:0] wr_addr_q, wr_addr_d;
  logic [CntW-1:0]           wr_left_q, wr_left_d;
  logic [bms_pkg::SizeW-1:0] wr_size_q, wr_size_d;

  // Two-entry result queue in front of the output channel. It lets the
  // memory keep streaming one beat per cycle while the sink stalls briefly.
  bms_pkg::rsp_t ent_q [2];
  logic          wptr_q, rptr_q;
  logic [1:0]    cnt_q;
  logic          push;
  bms_pkg::rsp_t push_item;
  logic          pop;
  logic [2:0]    occ;
  logic          room;

  logic          accept;
  logic [7:0]    req_beats;
  logic [7:0]    req_beats_clamped;
  logic          wr_in_range;
  logic          rd_in_range;
  logic          wr_last;

  assign pop    = out_o.valid && out_o.ready;
  // Occupancy the queue will have once the pending read data is pushed.
  assign occ    = {1'b0, cnt_q} + {2'b00, inf_q} - {2'b00, pop};
  assign room   = (occ <= 3'd1);
  assign accept = in_i.valid && in_i.ready;

  assign clr_done = (clr_q == MemAw'(MEM_WORDS - 1));

  // Beat count of a request: burst_len + 1, capped at MAX_BEATS.
  assign req_beats         = 8'(in_i.burst_len) + 8'd1;
  assign req_beats_clamped = (req_beats > 8'(MAX_BEATS)) ? 8'(MAX_BEATS) : req_beats;

  assign wr_in_range = ({2'b00, wr_addr_q[bms_pkg::AddrW-1:2]} < 32'(MEM_WORDS));
  assign rd_in_range = ({2'b00, rd_addr_q[bms_pkg::AddrW-1:2]} < 32'(MEM_WORDS));
  assign wr_last     = (wr_left_q <= CntW'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bms_pkg::ST_CLEAR: begin
        if (clr_done) state_d = bms_pkg::ST_IDLE;
      end
      bms_pkg::ST_IDLE: begin
        if (accept && (in_i.opcode == bms_pkg::OP_READ) && !wr_open_q) begin
          state_d = bms_pkg::ST_READ;
        end
      end
      bms_pkg::ST_READ: begin
        if (mem_re && (rd_left_q == CntW'(1))) state_d = bms_pkg::ST_IDLE;
      end
      default: state_d = bms_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath updates of each state.
  always_comb begin
    in_i.ready = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wr_addr_q[MemAw+1:2];
    mem_raddr  = rd_addr_q[MemAw+1:2];
    mem_wdata  = in_i.write_data;
    clr_d      = clr_q;
    rd_addr_d  = rd_addr_q;
    rd_left_d  = rd_left_q;
    rd_size_d  = rd_size_q;
    inf_d      = 1'b0;
    inf_last_d = inf_last_q;
    inf_oor_d  = inf_oor_q;
    wr_open_d  = wr_open_q;
    wr_addr_d  = wr_addr_q;
    wr_left_d  = wr_left_q;
    wr_size_d  = wr_size_q;
    push       = 1'b0;
    push_item  = '{kind: bms_pkg::KindWriteRsp, read_data: '0, last: 1'b1};

    // Data of the read issued in the previous cycle joins the queue.
    if (inf_q) begin
      push      = 1'b1;
      push_item = '{kind: bms_pkg::KindReadBeat,
                    read_data: inf_oor_q ? '0 : mem_rdata_q,
                    last: inf_last_q};
    end

    unique case (state_q)
      bms_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + MemAw'(1);
      end
      bms_pkg::ST_IDLE: begin
        in_i.ready = room;
        if (accept) begin
          unique case (in_i.opcode)
            bms_pkg::OP_READ: begin
              if (!wr_open_q) begin
                rd_addr_d = in_i.byte_address;
                rd_left_d = CntW'(req_beats_clamped);
                rd_size_d = in_i.size_log2;
              end
            end
            bms_pkg::OP_WRITE_REQ: begin
              if (!wr_open_q) begin
                wr_open_d = 1'b1;
                wr_addr_d = in_i.byte_address;
                wr_left_d = CntW'(req_beats_clamped);
                wr_size_d = in_i.size_log2;
              end
            end
            bms_pkg::OP_WRITE_DATA: begin
              if (wr_open_q) begin
                // Out-of-range words are dropped, but the burst still advances.
                mem_we    = wr_in_range;
                wr_addr_d = wr_addr_q + (32'd1 << wr_size_q);
                wr_left_d = wr_left_q - CntW'(1);
                if (wr_last) begin
                  wr_open_d = 1'b0;
                  wr_left_d = '0;
                  push      = 1'b1;
                  push_item = '{kind: bms_pkg::KindWriteRsp, read_data: '0, last: 1'b1};
                end
              end
            end
            default: ;
          endcase
        end
      end
      bms_pkg::ST_READ: begin
        mem_re = room;
        if (room) begin
          inf_d      = 1'b1;
          inf_last_d = (rd_left_q == CntW'(1));
          inf_oor_d  = !rd_in_range;
          rd_addr_d  = rd_addr_q + (32'd1 << rd_size_q);
          rd_left_d  = rd_left_q - CntW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wptr_q] <= push_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bms_pkg::ST_CLEAR;
      clr_q      <= '0;
      rd_addr_q  <= '0;
      rd_left_q  <= '0;
      rd_size_q  <= '0;
      inf_q      <= 1'b0;
      inf_last_q <= 1'b0;
      inf_oor_q  <= 1'b0;
      wr_open_q  <= 1'b0;
      wr_addr_q  <= '0;
      wr_left_q  <= '0;
      wr_size_q  <= '0;
      wptr_q     <= 1'b0;
      rptr_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      rd_addr_q  <= rd_addr_d;
      rd_left_q  <= rd_left_d;
      rd_size_q  <= rd_size_d;
      inf_q      <= inf_d;
      inf_last_q <= inf_last_d;
      inf_oor_q  <= inf_oor_d;
      wr_open_q  <= wr_open_d;
      wr_addr_q  <= wr_addr_d;
      wr_left_q  <= wr_left_d;
      wr_size_q  <= wr_size_d;
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      cnt_q      <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_o.valid     = (cnt_q != 2'd0);
  assign out_o.kind      = ent_q[rptr_q].kind;
  assign out_o.read_data = ent_q[rptr_q].read_data;
  assign out_o.last      = ent_q[rptr_q].last;

endmodule

// ===== verif/burst_memory_slave_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of burst_memory_slave_unit: directed and random
// request, write data and noise items checked against an in-bench memory model.
// Depends on bms_pkg, the channel interfaces in bms_if.sv and the RTL top level.
module burst_memory_slave_unit_test;

  localparam int unsigned MemWords = bms_pkg::MemWordsDef;
  localparam int unsigned MaxBeats = bms_pkg::MaxBeatsDef;
  localparam logic [bms_pkg::OpW-1:0] OpUnused = 2'd3;
  // Cycles allowed for a late result after the last expected one has arrived.
  localparam int unsigned DrainCycles = 40;

  logic clk;
  logic rst_n;

  bms_in_if  req_ch ();
  bms_out_if rsp_ch ();

  burst_memory_slave_unit u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_ch),
    .out_o  (rsp_ch)
  );

  // Memory model and open write burst, mirroring what the block should hold.
  logic [bms_pkg::DataW-1:0] mem_model [MemWords];
  logic                      wr_open;
  logic [bms_pkg::AddrW-1:0] wr_addr;
  logic [4:0]                wr_left;
  logic [bms_pkg::SizeW-1:0] wr_step;

  bms_pkg::rsp_t expected_beats [$];
  int unsigned   mismatch_count;

  // Idling switches for either side and the long output hold-off request.
  bit          src_idle_on;
  bit          sink_idle_on;
  int unsigned stall_left;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The run is cut off well beyond the slowest legal completion.
  initial begin
    #(10_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned beat_count(logic [bms_pkg::LenW-1:0] len);
    int unsigned n;
    n = len + 1;
    if (n > MaxBeats) n = MaxBeats;
    return n;
  endfunction

  // Appends one expected result behind the ones already waiting.
  function automatic void expect_result(bms_pkg::rsp_t beat);
    expected_beats = {expected_beats, beat};
  endfunction

  // Works out the results one accepted item causes and updates the model.
  function automatic void predict_item(logic [bms_pkg::OpW-1:0] op,
                                       logic [bms_pkg::AddrW-1:0] addr,
                                       logic [bms_pkg::LenW-1:0] len,
                                       logic [bms_pkg::SizeW-1:0] sz,
                                       logic [bms_pkg::DataW-1:0] wdata);
    bms_pkg::rsp_t             beat;
    int unsigned               n;
    logic [bms_pkg::AddrW-1:0] beat_addr;
    case (op)
      bms_pkg::OP_READ: begin
        if (!wr_open) begin
          n = beat_count(len);
          for (int unsigned b = 0; b < n; b++) begin
            // Beat addresses wrap at 32 bits; words past the store read as zero.
            beat_addr      = addr + (b << sz);
            beat.kind      = bms_pkg::KindReadBeat;
            beat.read_data = (beat_addr[bms_pkg::AddrW-1:2] < MemWords) ?
                             mem_model[beat_addr[bms_pkg::AddrW-1:2]] : '0;
            beat.last      = (b + 1 == n);
            expect_result(beat);
          end
        end
      end
      bms_pkg::OP_WRITE_REQ: begin
        // A request inside an open write burst is dropped.
        if (!wr_open) begin
          wr_open = 1'b1;
          wr_addr = addr;
          wr_left = 5'(beat_count(len));
          wr_step = sz;
        end
      end
      bms_pkg::OP_WRITE_DATA: begin
        if (wr_open) begin
          if (wr_addr[bms_pkg::AddrW-1:2] < MemWords)
            mem_model[wr_addr[bms_pkg::AddrW-1:2]] = wdata;
          wr_addr = wr_addr + (32'd1 << wr_step);
          if (wr_left > 0) wr_left--;
          if (wr_left == 0) begin
            wr_open = 1'b0;
            beat    = '{kind: bms_pkg::KindWriteRsp, read_data: '0, last: 1'b1};
            expect_result(beat);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Offers one item, optionally after an idle burst, and waits until it is taken.
  // Entered and left just after a falling edge.
  task automatic send_item(input logic [bms_pkg::OpW-1:0] op,
                           input logic [bms_pkg::AddrW-1:0] addr,
                           input logic [bms_pkg::LenW-1:0] len,
                           input logic [bms_pkg::SizeW-1:0] sz,
                           input logic [bms_pkg::DataW-1:0] wdata);
    int unsigned gap;
    gap = 0;
    if (src_idle_on && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.opcode       = op;
    req_ch.byte_address = addr;
    req_ch.burst_len    = len;
    req_ch.size_log2    = sz;
    req_ch.write_data   = wdata;
    do @(posedge clk); while (!req_ch.ready);
    predict_item(op, addr, len, sz, wdata);
    @(negedge clk);
  endtask

  function automatic logic [bms_pkg::DataW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly inside the store, sometimes at its top, past it, or near the wrap point.
  function automatic logic [bms_pkg::AddrW-1:0] rand_address();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      2:       return MemWords * 4 - $urandom_range(0, 2048);
      default: return $urandom_range(0, MemWords * 4 - 1);
    endcase
  endfunction

  // Write data with random don't-care request fields.
  task automatic send_data(input logic [bms_pkg::DataW-1:0] wdata);
    send_item(bms_pkg::OP_WRITE_DATA, $urandom, 4'($urandom), 3'($urandom), wdata);
  endtask

  task automatic send_read(input logic [bms_pkg::AddrW-1:0] addr,
                           input logic [bms_pkg::LenW-1:0] len,
                           input logic [bms_pkg::SizeW-1:0] sz);
    send_item(bms_pkg::OP_READ, addr, len, sz, $urandom);
  endtask

  // A complete write burst: the request and exactly as many data items as it needs.
  task automatic write_burst(input logic [bms_pkg::AddrW-1:0] addr,
                             input logic [bms_pkg::LenW-1:0] len,
                             input logic [bms_pkg::SizeW-1:0] sz);
    send_item(bms_pkg::OP_WRITE_REQ, addr, len, sz, $urandom);
    repeat (beat_count(len)) send_data(rand_word());
  endtask

  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Result side: random ready bursts, plus a long hold-off counted down here.
  initial begin : result_sink
    int unsigned idle_left;
    idle_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready = 1'b0;
      end else if (idle_left > 0) begin
        idle_left--;
        rsp_ch.ready = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 7) == 0) begin
        idle_left    = $urandom_range(1, 15) - 1;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    bms_pkg::rsp_t got;
    bms_pkg::rsp_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = '{kind: rsp_ch.kind, read_data: rsp_ch.read_data, last: rsp_ch.last};
      if (expected_beats.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: unexpected result kind=%0b data=%h last=%0b",
                   $realtime, got.kind, got.read_data, got.last);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.read_data !== want.read_data ||
            got.last !== want.last) begin
          if (mismatch_count < 10)
            $display({"%0t: result mismatch: expected kind=%0b data=%h last=%0b,",
                      " got kind=%0b data=%h last=%0b"},
                     $realtime, want.kind, want.read_data, want.last,
                     got.kind, got.read_data, got.last);
          mismatch_count++;
        end
      end
    end
  end

  // Fresh store: zero everywhere, including the last word and beyond it.
  task automatic test_cleared_memory();
    send_read(32'h0, 4'd15, 3'd2);
    send_read(MemWords * 4 - 4, 4'd1, 3'd2);
  endtask

  // Data extremes, the top word of the store, wraparound and the largest steps.
  task automatic test_burst_extremes();
    send_item(bms_pkg::OP_WRITE_REQ, 32'h0, 4'd1, 3'd2, $urandom);
    send_data(32'h0000_0000);
    send_data(32'hFFFF_FFFF);
    send_read(32'h0, 4'd1, 3'd2);
    // The second beat lands past the store and is dropped.
    write_burst(MemWords * 4 - 4, 4'd1, 3'd2);
    send_read(MemWords * 4 - 8, 4'd2, 3'd2);
    send_read(32'hFFFF_FFFC, 4'd2, 3'd2);
    send_read(32'h0, 4'd15, 3'd7);
    send_read(32'h3, 4'd3, 3'd0);
    // Starts beyond the store and wraps around into words zero and one.
    write_burst(32'hFFFF_FFF8, 4'd3, 3'd2);
    send_read(32'hFFFF_FFFF, 4'd15, 3'd0);
  endtask

  // Requests inside an open burst, stray data and the unused opcode do nothing.
  task automatic test_ignored_items();
    send_item(bms_pkg::OP_WRITE_REQ, 32'd64, 4'd1, 3'd2, $urandom);
    send_read(32'd64, 4'd3, 3'd2);
    send_item(bms_pkg::OP_WRITE_REQ, 32'd128, 4'd7, 3'd0, $urandom);
    send_item(OpUnused, $urandom, 4'($urandom), 3'($urandom), $urandom);
    send_data(rand_word());
    send_data(rand_word());
    send_data(rand_word());
    send_item(OpUnused, $urandom, 4'($urandom), 3'($urandom), $urandom);
    send_read(32'd64, 4'd1, 3'd2);
  endtask

  // The receiver holds off long enough for the block to back up into its input.
  task automatic test_output_stall();
    wait_drained();
    stall_left = 400;
    repeat (12) send_read(rand_address(), 4'd15, 3'($urandom_range(0, 7)));
    wait_drained();
  endtask

  // Mostly well-formed reads and write bursts with random content, plus noise.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done;
    int unsigned pick;
    logic [bms_pkg::LenW-1:0] len;
    done = 0;
    while (done < n_items) begin
      // Just after the item count passes a multiple of a hundred, the idling on either side is reshuffled.
      if (done % 100 < 3) begin
        src_idle_on  = $urandom_range(0, 3) != 0;
        sink_idle_on = $urandom_range(0, 3) != 0;
      end
      pick = $urandom_range(0, 99);
      len  = 4'($urandom);
      if (pick < 45) begin
        send_read(rand_address(), len, 3'($urandom));
        done++;
      end else if (pick < 85) begin
        send_item(bms_pkg::OP_WRITE_REQ, rand_address(), len, 3'($urandom), $urandom);
        for (int unsigned b = 0; b < beat_count(len); b++) begin
          if ($urandom_range(0, 19) == 0)
            send_item(2'($urandom_range(0, 1)), $urandom, 4'($urandom), 3'($urandom),
                      $urandom);
          send_data(rand_word());
        end
        done += beat_count(len) + 1;
      end else begin
        case ($urandom_range(0, 2))
          0:       send_data($urandom);
          1:       send_item(OpUnused, $urandom, 4'($urandom), 3'($urandom), $urandom);
          default: begin
            // A short burst left open until a read bounces off it.
            send_item(bms_pkg::OP_WRITE_REQ, rand_address(), 4'd0, 3'($urandom),
                      $urandom);
            send_read(rand_address(), 4'($urandom), 3'($urandom));
            send_data(rand_word());
            done += 2;
          end
        endcase
      end
    end
  endtask

  // Back-to-back traffic with both sides always ready.
  task automatic test_steady_stream(input int unsigned n_items);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    for (int unsigned i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 1) == 0)
        send_read(rand_address(), 4'($urandom), 3'($urandom));
      else
        write_burst(rand_address(), 4'($urandom_range(0, 3)), 3'($urandom));
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.opcode       = bms_pkg::OP_READ;
    req_ch.byte_address = '0;
    req_ch.burst_len    = '0;
    req_ch.size_log2    = '0;
    req_ch.write_data   = '0;
    foreach (mem_model[i]) mem_model[i] = '0;
    wr_open        = 1'b0;
    wr_addr        = '0;
    wr_left        = '0;
    wr_step        = '0;
    mismatch_count = 0;
    stall_left     = 0;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The block clears its store first; the sender simply waits for ready.
    test_cleared_memory();
    test_burst_extremes();
    test_ignored_items();
    test_output_stall();
    test_random_traffic(400);
    wait_drained();
    test_steady_stream(25);

    req_ch.valid = 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatch_count == 0 && expected_beats.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
